FILE: src/qalu_pkg.sv
// Shared types, codes and saturation helpers for the quaternion unit.
// No dependencies; every other source file imports this package.
package qalu_pkg;

  localparam int QW  = 35;  // quotient bits per divider lane
  localparam int NW  = 97;  // dividend width
  localparam int DW  = 65;  // divisor width
  localparam int RS  = 18;  // square-root stages
  localparam int SQW = 36;  // square-root datapath width

  localparam logic [30:0] NSQ_MAX = '1;

  typedef enum logic [3:0] {
    MODE_ADD   = 4'd0,
    MODE_SUB   = 4'd1,
    MODE_PROD  = 4'd2,
    MODE_SCALE = 4'd3,
    MODE_DIV   = 4'd4,
    MODE_CONJ  = 4'd5,
    MODE_NORM  = 4'd6,
    MODE_NORMZ = 4'd7,
    MODE_INV   = 4'd8
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_SAT = 2'd1,
    ST_DZ  = 2'd2
  } status_e;

  typedef struct packed {
    logic [3:0]        mode;
    logic [3:0][31:0]  r;
    logic              sat;
    logic [30:0]       nsq;
    logic              dz;
    logic [3:0]        neg;
    logic [3:0]        ovf;
    logic [3:0][35:0]  qr;
  } side_t;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] nlo;
    logic [QW-1:0] q;
    logic [DW-1:0] d;
  } div_lane_t;

  typedef struct packed {
    logic [SQW-1:0] op;
    logic [SQW-1:0] res;
  } sqrt_lane_t;

  function automatic logic [31:0] mag32(logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // {saturated, value}
  function automatic logic [32:0] sat32(logic signed [65:0] v);
    if (v > 66'sd2147483647) return {1'b1, 32'h7fff_ffff};
    if (v < -66'sd2147483648) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  function automatic logic [32:0] signed_sat(logic [35:0] q, logic neg);
    if (neg) begin
      if (q > 36'd2147483648) return {1'b1, 32'h8000_0000};
      return {1'b0, 32'd0 - q[31:0]};
    end
    if (q > 36'd2147483647) return {1'b1, 32'h7fff_ffff};
    return {1'b0, q[31:0]};
  endfunction

endpackage

FILE: src/qalu_front.sv
// Front end: multiplier array, product and norm sums, divider setup.
// Three register stages; depends on qalu_pkg.
module qalu_front import qalu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [3:0]           mode_i,
  input  logic [3:0][31:0]     a_i,
  input  logic [3:0][31:0]     b_i,
  input  logic [31:0]          s_i,
  output logic                 valid_o,
  output side_t                side_o,
  output div_lane_t [3:0]      lane_o
);

  function automatic logic signed [65:0] sx64(logic [63:0] v);
    return $signed({{2{v[63]}}, v});
  endfunction

  // stage 1
  logic                v1_q;
  logic [3:0]          mode1_q;
  logic [3:0][31:0]    a1_q;
  logic [31:0]         s1_q;
  logic signed [63:0]  p1_d [4][4];
  logic signed [63:0]  p1_q [4][4];
  logic [62:0]         sq1_d [4];
  logic [62:0]         sq1_q [4];
  logic signed [32:0]  as1_d [4];
  logic signed [32:0]  as1_q [4];

  always_comb begin
    logic [31:0] am;
    logic [63:0] sqf;
    logic [31:0] bs;
    for (int i = 0; i < 4; i++) begin
      am = mag32(a_i[i]);
      sqf = am * am;
      sq1_d[i] = sqf[62:0];
      if (mode_i == MODE_SUB) begin
        as1_d[i] = $signed({a_i[i][31], a_i[i]}) - $signed({b_i[i][31], b_i[i]});
      end else begin
        as1_d[i] = $signed({a_i[i][31], a_i[i]}) + $signed({b_i[i][31], b_i[i]});
      end
      for (int j = 0; j < 4; j++) begin
        bs = (mode_i == MODE_SCALE) ? s_i : b_i[j];
        p1_d[i][j] = $signed(a_i[i]) * $signed(bs);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode1_q <= mode_i;
      a1_q    <= a_i;
      s1_q    <= s_i;
      p1_q    <= p1_d;
      sq1_q   <= sq1_d;
      as1_q   <= as1_d;
    end
  end

  // stage 2
  logic                v2_q;
  logic [3:0]          mode2_q;
  logic [3:0][31:0]    a2_q;
  logic [31:0]         s2_q;
  logic signed [65:0]  sum2_d [4];
  logic signed [65:0]  sum2_q [4];
  logic [64:0]         nrm2_d;
  logic [64:0]         nrm2_q;
  logic [62:0]         sq2_q [4];
  logic signed [32:0]  as2_q [4];

  always_comb begin
    if (mode1_q == MODE_SCALE) begin
      for (int i = 0; i < 4; i++) sum2_d[i] = sx64(p1_q[i][0]);
    end else begin
      sum2_d[0] = sx64(p1_q[0][0]) - sx64(p1_q[1][1]) - sx64(p1_q[2][2]) - sx64(p1_q[3][3]);
      sum2_d[1] = sx64(p1_q[0][1]) + sx64(p1_q[1][0]) + sx64(p1_q[2][3]) - sx64(p1_q[3][2]);
      sum2_d[2] = sx64(p1_q[0][2]) - sx64(p1_q[1][3]) + sx64(p1_q[2][0]) + sx64(p1_q[3][1]);
      sum2_d[3] = sx64(p1_q[0][3]) + sx64(p1_q[1][2]) - sx64(p1_q[2][1]) + sx64(p1_q[3][0]);
    end
    nrm2_d = 65'(sq1_q[0]) + 65'(sq1_q[1]) + 65'(sq1_q[2]) + 65'(sq1_q[3]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode2_q <= mode1_q;
      a2_q    <= a1_q;
      s2_q    <= s1_q;
      sum2_q  <= sum2_d;
      nrm2_q  <= nrm2_d;
      sq2_q   <= sq1_q;
      as2_q   <= as1_q;
    end
  end

  // stage 3
  logic             v3_q;
  side_t            side_d, side_q;
  div_lane_t [3:0]  lane_d, lane_q;

  always_comb begin
    logic [48:0]        nx;
    logic [31:0]        am;
    logic [31:0]        sm;
    logic [NW-1:0]      n;
    logic [DW-1:0]      d;
    logic               neg;
    logic [32:0]        sv;
    logic signed [65:0] rnd;
    logic               nsat;
    logic               satacc;
    logic               szero;
    side_d = '0;
    lane_d = '0;
    side_d.mode = mode2_q;
    sm = mag32(s2_q);
    szero = (nrm2_q == '0);
    nsat = 1'b0;
    satacc = 1'b0;
    nx = '0;
    if (nrm2_q[64]) begin
      side_d.nsq = NSQ_MAX;
      nsat = 1'b1;
    end else begin
      nx = {1'b0, nrm2_q[63:16]} + 49'(nrm2_q[15]);
      if (nx > 49'(NSQ_MAX)) begin
        side_d.nsq = NSQ_MAX;
        nsat = 1'b1;
      end else begin
        side_d.nsq = nx[30:0];
      end
    end
    for (int i = 0; i < 4; i++) begin
      am = mag32(a2_q[i]);
      rnd = (sum2_q[i] + 66'sd32768) >>> 16;
      unique case (mode2_q)
        MODE_ADD, MODE_SUB:    sv = sat32(66'(as2_q[i]));
        MODE_PROD, MODE_SCALE: sv = sat32(rnd);
        MODE_CONJ: begin
          if (i == 0) sv = {1'b0, a2_q[0]};
          else sv = sat32(66'sd0 - 66'($signed(a2_q[i])));
        end
        default:               sv = '0;
      endcase
      side_d.r[i] = sv[31:0];
      satacc = satacc | sv[32];
      unique case (mode2_q)
        MODE_DIV: begin
          n = NW'(am) << 16;
          d = DW'(sm);
          neg = a2_q[i][31] ^ s2_q[31];
        end
        MODE_NORMZ: begin
          n = {sq2_q[i], 34'b0};
          d = nrm2_q;
          neg = a2_q[i][31];
        end
        MODE_INV: begin
          n = NW'(am) << 32;
          d = nrm2_q;
          neg = (i == 0) ? a2_q[i][31] : (!a2_q[i][31] && (a2_q[i] != '0));
        end
        default: begin
          n = '0;
          d = '0;
          neg = 1'b0;
        end
      endcase
      side_d.neg[i] = neg;
      side_d.ovf[i] = ({3'b0, n} >= {d, {QW{1'b0}}});
      lane_d[i].rem = {3'b0, n[NW-1:QW]};
      lane_d[i].nlo = n[QW-1:0];
      lane_d[i].q   = '0;
      lane_d[i].d   = d;
    end
    side_d.sat = (mode2_q == MODE_NORM) ? nsat : satacc;
    side_d.dz  = ((mode2_q == MODE_DIV) && (s2_q == '0)) ||
                 (((mode2_q == MODE_NORMZ) || (mode2_q == MODE_INV)) && szero);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_d;
      lane_q <= lane_d;
    end
  end

  assign valid_o = v3_q;
  assign side_o  = side_q;
  assign lane_o  = lane_q;

endmodule

FILE: src/qalu_div.sv
// Four-lane restoring divider, one quotient bit per stage, plus a rounding stage.
// Depends on qalu_pkg.
module qalu_div import qalu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  side_t             side_i,
  input  div_lane_t [3:0]   lane_i,
  output logic              valid_o,
  output side_t             side_o,
  output sqrt_lane_t [3:0]  lane_o
);

  logic             vld_q  [QW];
  side_t            side_q [QW];
  div_lane_t [3:0]  lane_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic             v_in;
    side_t            s_in;
    div_lane_t [3:0]  l_in;
    div_lane_t [3:0]  l_nx;

    if (k == 0) begin : g_first
      assign v_in = valid_i;
      assign s_in = side_i;
      assign l_in = lane_i;
    end else begin : g_next
      assign v_in = vld_q[k-1];
      assign s_in = side_q[k-1];
      assign l_in = lane_q[k-1];
    end

    always_comb begin
      logic [DW:0] t;
      logic [DW:0] dd;
      logic        ge;
      for (int i = 0; i < 4; i++) begin
        t  = {l_in[i].rem, l_in[i].nlo[QW-1]};
        dd = {1'b0, l_in[i].d};
        ge = (t >= dd);
        l_nx[i].rem = ge ? DW'(t - dd) : DW'(t);
        l_nx[i].nlo = {l_in[i].nlo[QW-2:0], 1'b0};
        l_nx[i].q   = {l_in[i].q[QW-2:0], ge};
        l_nx[i].d   = l_in[i].d;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= s_in;
        lane_q[k] <= l_nx;
      end
    end
  end

  // rounding: 2*rem >= d bumps the quotient
  logic              rv_q;
  side_t             rside_d, rside_q;
  sqrt_lane_t [3:0]  rlane_d, rlane_q;

  always_comb begin
    logic up;
    rside_d = side_q[QW-1];
    for (int i = 0; i < 4; i++) begin
      up = ({lane_q[QW-1][i].rem, 1'b0} >= {1'b0, lane_q[QW-1][i].d});
      rside_d.qr[i]  = {1'b0, lane_q[QW-1][i].q} + 36'(up);
      rlane_d[i].op  = SQW'(lane_q[QW-1][i].q);
      rlane_d[i].res = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else if (en_i) begin
      rv_q <= vld_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rside_q <= rside_d;
      rlane_q <= rlane_d;
    end
  end

  assign valid_o = rv_q;
  assign side_o  = rside_q;
  assign lane_o  = rlane_q;

endmodule

FILE: src/qalu_sqrt.sv
// Four-lane digit-by-digit integer square root, one root bit per stage.
// Depends on qalu_pkg.
module qalu_sqrt import qalu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  side_t             side_i,
  input  sqrt_lane_t [3:0]  lane_i,
  output logic              valid_o,
  output side_t             side_o,
  output logic [3:0][17:0]  root_o
);

  logic              vld_q  [RS];
  side_t             side_q [RS];
  sqrt_lane_t [3:0]  lane_q [RS];

  for (genvar k = 0; k < RS; k++) begin : g_stage
    localparam logic [SQW-1:0] ONE = {{(SQW-1){1'b0}}, 1'b1} << (2 * (RS - 1 - k));
    logic              v_in;
    side_t             s_in;
    sqrt_lane_t [3:0]  l_in;
    sqrt_lane_t [3:0]  l_nx;

    if (k == 0) begin : g_first
      assign v_in = valid_i;
      assign s_in = side_i;
      assign l_in = lane_i;
    end else begin : g_next
      assign v_in = vld_q[k-1];
      assign s_in = side_q[k-1];
      assign l_in = lane_q[k-1];
    end

    always_comb begin
      logic [SQW-1:0] trial;
      for (int i = 0; i < 4; i++) begin
        trial = l_in[i].res + ONE;
        if (l_in[i].op >= trial) begin
          l_nx[i].op  = l_in[i].op - trial;
          l_nx[i].res = (l_in[i].res >> 1) + ONE;
        end else begin
          l_nx[i].op  = l_in[i].op;
          l_nx[i].res = l_in[i].res >> 1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= s_in;
        lane_q[k] <= l_nx;
      end
    end
  end

  assign valid_o = vld_q[RS-1];
  assign side_o  = side_q[RS-1];
  for (genvar i = 0; i < 4; i++) begin : g_root
    assign root_o[i] = lane_q[RS-1][i].res[17:0];
  end

endmodule

FILE: src/quaternion_alu.sv
// Top level of the quaternion unit: stream ports, pipeline chain, output register.
// Depends on qalu_pkg, qalu_front, qalu_div and qalu_sqrt.
//
//   channel  | dir | tdata (low bit up)                         | tuser
//   s_axis   | in  | a_w a_x a_y a_z b_w b_x b_y b_z scalar     | mode
//   m_axis   | out | r_w r_x r_y r_z norm_sq, zero pad          | status
//
// One beat per cycle in and out unless m_axis stalls. The chain is 3 front stages,
// 35 divider bit stages, 1 rounding stage, 18 root stages and 1 output register.
// The divider lanes set the depth: one quotient bit per stage.
// Reset clears the valid bits only. A stall on m_axis freezes the whole chain and
// drops s_axis_tready; no beat is lost or repeated.
module quaternion_alu import qalu_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [287:0]  s_axis_tdata,   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scalar
  input  logic [3:0]    s_axis_tuser,   // mode
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [159:0]  m_axis_tdata,   // r_w, r_x, r_y, r_z, norm_sq, pad
  output logic [1:0]    m_axis_tuser    // status
);

  logic              en;
  logic [3:0][31:0]  a, b;
  logic              fv, dv, sv;
  side_t             fside, dside, sside;
  div_lane_t [3:0]   flane;
  sqrt_lane_t [3:0]  dlane;
  logic [3:0][17:0]  root;

  logic              out_valid_q;
  logic [159:0]      out_data_d, out_data_q;
  logic [1:0]        out_user_d, out_user_q;

  assign en = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  for (genvar i = 0; i < 4; i++) begin : g_unpack
    assign a[i] = s_axis_tdata[32*i +: 32];
    assign b[i] = s_axis_tdata[128 + 32*i +: 32];
  end

  qalu_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .mode_i  (s_axis_tuser),
    .a_i     (a),
    .b_i     (b),
    .s_i     (s_axis_tdata[287:256]),
    .valid_o (fv),
    .side_o  (fside),
    .lane_o  (flane)
  );

  qalu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fv),
    .side_i  (fside),
    .lane_i  (flane),
    .valid_o (dv),
    .side_o  (dside),
    .lane_o  (dlane)
  );

  qalu_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv),
    .side_i  (dside),
    .lane_i  (dlane),
    .valid_o (sv),
    .side_o  (sside),
    .root_o  (root)
  );

  always_comb begin
    logic [3:0][31:0] r;
    logic [32:0]      lv;
    logic [18:0]      h;
    logic [31:0]      hv;
    logic             sat;
    status_e          st;
    sat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      h  = ({1'b0, root[i]} + 19'd1) >> 1;
      hv = 32'(h[17:0]);
      unique case (sside.mode)
        MODE_DIV, MODE_INV: begin
          if (sside.ovf[i]) lv = {1'b1, sside.neg[i] ? 32'h8000_0000 : 32'h7fff_ffff};
          else lv = signed_sat(sside.qr[i], sside.neg[i]);
        end
        MODE_NORMZ: lv = {1'b0, sside.neg[i] ? (32'd0 - hv) : hv};
        default:    lv = {1'b0, sside.r[i]};
      endcase
      r[i] = lv[31:0];
      sat = sat | lv[32];
    end
    sat = sat | sside.sat;
    if (sside.dz) begin
      r  = '0;
      st = ST_DZ;
    end else if (sat) begin
      st = ST_SAT;
    end else begin
      st = ST_OK;
    end
    out_data_d = {1'b0, sside.nsq, r[3], r[2], r[1], r[0]};
    out_user_d = st;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule
